/* hdl/hex_board_cell_neighbors_top_macros.svh */
// assertion macros for the hex board neighbour block
// used by hbcn_neighbors, the rtl file that carries concurrent assertions; needs nothing else
`ifndef HEX_BOARD_CELL_NEIGHBORS_TOP_MACROS_SVH
`define HEX_BOARD_CELL_NEIGHBORS_TOP_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define HBCN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define HBCN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/hbcn_pkg.sv */
// shared field widths, register codes and the configuration struct
// no dependencies; compiled before every other file of the block
package hbcn_pkg;

   localparam int IDX_W   = 12;
   localparam int RAD_W   = 6;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 6;
   localparam int NB_W    = 13;
   localparam int CELLS_W = 12;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // register index taken from paddr[2]
   localparam logic REG_BOARD_RADIUS = 1'b0;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd5;
   localparam logic [NB_W-1:0]  NO_CELL      = '1;

   // effective board settings derived from the radius register
   typedef struct packed {
      logic [RAD_W-1:0]   radius;
      logic [CELLS_W-1:0] cells;
   } cfg_type;

endpackage

/* hdl/hbcn_if.sv */
// request and response channel interfaces with valid/ready handshake
// depends on hbcn_pkg for the field widths
interface hbcn_req_if;
   import hbcn_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] cell_index;

   modport source (output valid, output cell_index, input ready);
   modport sink (input valid, input cell_index, output ready);
endinterface

interface hbcn_rsp_if;
   import hbcn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [COL_W-1:0] column;
   logic [ROW_W-1:0]        row;
   logic signed [NB_W-1:0]  nb_up;
   logic signed [NB_W-1:0]  nb_up_right;
   logic signed [NB_W-1:0]  nb_down_right;
   logic signed [NB_W-1:0]  nb_down;
   logic signed [NB_W-1:0]  nb_down_left;
   logic signed [NB_W-1:0]  nb_up_left;
   logic                    invalid;

   modport source (output valid, output column, output row, output nb_up,
                   output nb_up_right, output nb_down_right, output nb_down,
                   output nb_down_left, output nb_up_left, output invalid,
                   input ready);
   modport sink (input valid, input column, input row, input nb_up,
                 input nb_up_right, input nb_down_right, input nb_down,
                 input nb_down_left, input nb_up_left, input invalid,
                 output ready);
endinterface

/* hdl/hbcn_csr.sv */
// apb-style register port holding board_radius and its derived settings
// depends on hbcn_pkg
module hbcn_csr #(
   parameter int MAX_RADIUS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hbcn_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hbcn_pkg::DATA_W-1:0] csr_pwdata,
   output logic [hbcn_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output hbcn_pkg::cfg_type           cfg
);
   import hbcn_pkg::*;

   localparam int PW = 2 * RAD_W + 2;
   localparam logic [RAD_W-1:0] MAX_R = RAD_W'(MAX_RADIUS);

   // clamp the radius and work out the cell count 3r(r-1)+1
   function automatic cfg_type eff_cfg(input logic [RAD_W-1:0] raw);
      cfg_type          c;
      logic [RAD_W-1:0] r;
      logic [PW-1:0]    prod;
      r = raw;
      if (r == '0) r = RAD_W'(1);
      if (r > MAX_R) r = MAX_R;
      prod = PW'(r) * PW'(r - RAD_W'(1));
      c.radius = r;
      c.cells  = CELLS_W'(PW'(3) * prod + PW'(1));
      return c;
   endfunction

   logic             wr_en;
   logic [RAD_W-1:0] radius_raw_ff, radius_raw_in;
   cfg_type          cfg_ff, cfg_in;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      radius_raw_in = radius_raw_ff;
      cfg_in        = cfg_ff;
      if (wr_en && (csr_paddr[2] == REG_BOARD_RADIUS)) begin
         radius_raw_in = csr_pwdata[RAD_W-1:0];
         cfg_in        = eff_cfg(csr_pwdata[RAD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_raw_ff <= RADIUS_RESET;
         cfg_ff        <= eff_cfg(RADIUS_RESET);
      end else begin
         radius_raw_ff <= radius_raw_in;
         cfg_ff        <= cfg_in;
      end
   end

   // read back the raw register value
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_BOARD_RADIUS) begin
         csr_prdata = DATA_W'(radius_raw_ff);
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/hbcn_search_stage.sv */
// one step of the pipelined binary search for the cell's column
// depends on hbcn_pkg; tests one bit of the column number per stage
module hbcn_search_stage #(
   parameter int CW  = 6,
   parameter int BIT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hbcn_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [hbcn_pkg::IDX_W-1:0]   in_index,
   input  logic                         in_invalid,
   input  logic [CW-1:0]                in_col,
   input  logic [hbcn_pkg::IDX_W-1:0]   in_start,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [hbcn_pkg::IDX_W-1:0]   out_index,
   output logic                         out_invalid,
   output logic [CW-1:0]                out_col,
   output logic [hbcn_pkg::IDX_W-1:0]   out_start
);
   import hbcn_pkg::*;

   localparam int SW = 16;

   logic [CW-1:0]    trial;
   logic [SW-1:0]    t_w, r_w, lim_w, m_w, sum_w, st_w;
   logic             in_range, left_half, take;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             invalid_ff, invalid_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [IDX_W-1:0] start_ff, start_in;

   // start of the trial column: left half sums m columns of length r..r+m-1,
   // right half counts back from the cell total
   always_comb begin
      trial     = in_col | (CW'(1) << BIT);
      t_w       = SW'(trial);
      r_w       = SW'(cfg.radius);
      lim_w     = (r_w << 1) - SW'(2);
      in_range  = (t_w <= lim_w);
      left_half = (t_w < r_w);
      m_w       = left_half ? t_w : ((r_w << 1) - SW'(1) - t_w);
      sum_w     = (m_w * r_w) + ((m_w * (m_w - SW'(1))) >> 1);
      st_w      = left_half ? sum_w : (SW'(cfg.cells) - sum_w);
      take      = in_range && (st_w <= SW'(in_index));
   end

   assign in_ready = !valid_ff || out_ready;

   // stage register next values
   always_comb begin
      valid_in   = valid_ff;
      index_in   = index_ff;
      invalid_in = invalid_ff;
      col_in     = col_ff;
      start_in   = start_ff;
      if (in_ready) begin
         valid_in   = in_valid;
         index_in   = in_index;
         invalid_in = in_invalid;
         col_in     = take ? trial : in_col;
         start_in   = take ? st_w[IDX_W-1:0] : in_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      index_ff   <= index_in;
      invalid_ff <= invalid_in;
      col_ff     <= col_in;
      start_ff   <= start_in;
   end

   assign out_valid   = valid_ff;
   assign out_index   = index_ff;
   assign out_invalid = invalid_ff;
   assign out_col     = col_ff;
   assign out_start   = start_ff;

endmodule

/* hdl/hbcn_neighbors.sv */
// final stage: row, signed column and the six neighbour indices
// depends on hbcn_pkg, hbcn_rsp_if and the assertion macro header
`include "hex_board_cell_neighbors_top_macros.svh"

module hbcn_neighbors #(
   parameter int CW = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hbcn_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [hbcn_pkg::IDX_W-1:0] in_index,
   input  logic                       in_invalid,
   input  logic [CW-1:0]              in_col,
   input  logic [hbcn_pkg::IDX_W-1:0] in_start,
   hbcn_rsp_if.source                 rsp_if
);
   import hbcn_pkg::*;

   localparam int SW = 14;

   logic signed [SW-1:0] n_s, k_s, r_s, col_s, ac_s, last_s, row_s;
   logic signed [SW-1:0] up_s, upr_s, dnr_s, dn_s, dnl_s, upl_s;
   logic                 top_row, bot_row, col_neg, col_pos, col_first, col_last;

   logic                    valid_ff, valid_in;
   logic signed [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [NB_W-1:0]         up_ff, up_in, upr_ff, upr_in, dnr_ff, dnr_in;
   logic [NB_W-1:0]         dn_ff, dn_in, dnl_ff, dnl_in, upl_ff, upl_in;
   logic                    invalid_ff, invalid_in;

   // position of the cell on the board
   always_comb begin
      n_s       = $signed(SW'(in_index));
      k_s       = $signed(SW'(in_col));
      r_s       = $signed(SW'(cfg.radius));
      col_s     = k_s - r_s + SW'(1);
      ac_s      = (col_s < 0) ? -col_s : col_s;
      last_s    = (r_s <<< 1) - SW'(2) - ac_s;
      row_s     = $signed(SW'(in_index - in_start));
      top_row   = (row_s == '0);
      bot_row   = (row_s == last_s);
      col_neg   = (col_s < 0);
      col_pos   = (col_s > 0);
      col_first = (col_s == -(r_s - SW'(1)));
      col_last  = (col_s == (r_s - SW'(1)));
   end

   // neighbour indices, all ones where off the board
   always_comb begin
      up_s  = top_row ? -SW'(1) : (n_s - SW'(1));
      dn_s  = bot_row ? -SW'(1) : (n_s + SW'(1));
      upr_s = ((top_row && !col_neg) || col_last) ? -SW'(1)
            : (n_s + (r_s <<< 1) - ac_s - SW'(2) + (col_neg ? SW'(1) : SW'(0)));
      dnr_s = ((bot_row && !col_neg) || col_last) ? -SW'(1)
            : (n_s + (r_s <<< 1) - ac_s - (col_neg ? SW'(0) : SW'(1)));
      dnl_s = ((bot_row && !col_pos) || col_first) ? -SW'(1)
            : (n_s - (r_s <<< 1) + ac_s + SW'(2) - (col_pos ? SW'(1) : SW'(0)));
      upl_s = ((top_row && !col_pos) || col_first) ? -SW'(1)
            : (n_s - (r_s <<< 1) + ac_s + (col_pos ? SW'(0) : SW'(1)));
   end

   assign in_ready = !valid_ff || rsp_if.ready;

   // output register next values; an off-board index gives all zeros
   always_comb begin
      valid_in   = valid_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      up_in      = up_ff;
      upr_in     = upr_ff;
      dnr_in     = dnr_ff;
      dn_in      = dn_ff;
      dnl_in     = dnl_ff;
      upl_in     = upl_ff;
      invalid_in = invalid_ff;
      if (in_ready) begin
         valid_in   = in_valid;
         invalid_in = in_invalid;
         if (in_invalid) begin
            column_in = '0;
            row_in    = '0;
            up_in     = '0;
            upr_in    = '0;
            dnr_in    = '0;
            dn_in     = '0;
            dnl_in    = '0;
            upl_in    = '0;
         end else begin
            column_in = col_s[COL_W-1:0];
            row_in    = row_s[ROW_W-1:0];
            up_in     = up_s[NB_W-1:0];
            upr_in    = upr_s[NB_W-1:0];
            dnr_in    = dnr_s[NB_W-1:0];
            dn_in     = dn_s[NB_W-1:0];
            dnl_in    = dnl_s[NB_W-1:0];
            upl_in    = upl_s[NB_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      column_ff  <= column_in;
      row_ff     <= row_in;
      up_ff      <= up_in;
      upr_ff     <= upr_in;
      dnr_ff     <= dnr_in;
      dn_ff      <= dn_in;
      dnl_ff     <= dnl_in;
      upl_ff     <= upl_in;
      invalid_ff <= invalid_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.column        = column_ff;
   assign rsp_if.row           = row_ff;
   assign rsp_if.nb_up         = $signed(up_ff);
   assign rsp_if.nb_up_right   = $signed(upr_ff);
   assign rsp_if.nb_down_right = $signed(dnr_ff);
   assign rsp_if.nb_down       = $signed(dn_ff);
   assign rsp_if.nb_down_left  = $signed(dnl_ff);
   assign rsp_if.nb_up_left    = $signed(upl_ff);
   assign rsp_if.invalid       = invalid_ff;

   // checks on the result register
   `HBCN_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !valid_ff, "output valid after reset")
   `HBCN_ASSERT_IMPL(a_invalid_zero, clock, reset, valid_ff && invalid_ff, (column_ff == '0) && (row_ff == '0) && (up_ff == '0) && (dnl_ff == '0), "off-board transaction with non-zero fields")
   `HBCN_ASSERT_IMPL(a_top_row_up, clock, reset, valid_ff && !invalid_ff, (row_ff == '0) == (up_ff == NO_CELL), "up neighbour disagrees with row")
   `HBCN_ASSERT_IMPL(a_row_in_column, clock, reset, valid_ff && !invalid_ff, (ROW_W + 1)'(row_ff) <= (ROW_W + 1)'(cfg.radius) * (ROW_W + 1)'(2) - (ROW_W + 1)'(2), "row beyond column length")

endmodule

/* hdl/hex_board_cell_neighbors_top.sv */
// pipeline: clog2(2*MAX_RADIUS-1) search stages plus one result stage
// throughput: one transaction per cycle while rsp ready stays high; each search stage settles one column bit
// stalls hold every stage in place through a ready chain, nothing is dropped
// reset: synchronous, clears all stage valid bits and sets board_radius to 5
// top level of the hex board neighbour block
// depends on hbcn_pkg, hbcn_if, hbcn_csr, hbcn_search_stage, hbcn_neighbors
module hex_board_cell_neighbors_top #(
   parameter int MAX_RADIUS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   hbcn_req_if.sink                    req_if,
   hbcn_rsp_if.source                  rsp_if,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hbcn_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hbcn_pkg::DATA_W-1:0] csr_pwdata,
   output logic [hbcn_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import hbcn_pkg::*;

   localparam int NCOL = 2 * MAX_RADIUS - 1;
   localparam int CW   = ($clog2(NCOL) > 0) ? $clog2(NCOL) : 1;

   cfg_type          cfg;
   logic             st_valid   [0:CW];
   logic             st_ready   [0:CW];
   logic [IDX_W-1:0] st_index   [0:CW];
   logic             st_invalid [0:CW];
   logic [CW-1:0]    st_col     [0:CW];
   logic [IDX_W-1:0] st_start   [0:CW];

   hbcn_csr #(.MAX_RADIUS(MAX_RADIUS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // search entry: column 0 starts at cell 0, off-board check against cell count
   assign st_valid[0]   = req_if.valid;
   assign req_if.ready  = st_ready[0];
   assign st_index[0]   = req_if.cell_index;
   assign st_invalid[0] = (req_if.cell_index >= cfg.cells);
   assign st_col[0]     = '0;
   assign st_start[0]   = '0;

   // one stage per column bit, most significant first
   for (genvar i = 0; i < CW; i++) begin : g_search
      hbcn_search_stage #(.CW(CW), .BIT(CW - 1 - i)) u_stage (
         .clock       (clock),
         .reset       (reset),
         .cfg         (cfg),
         .in_valid    (st_valid[i]),
         .in_ready    (st_ready[i]),
         .in_index    (st_index[i]),
         .in_invalid  (st_invalid[i]),
         .in_col      (st_col[i]),
         .in_start    (st_start[i]),
         .out_valid   (st_valid[i+1]),
         .out_ready   (st_ready[i+1]),
         .out_index   (st_index[i+1]),
         .out_invalid (st_invalid[i+1]),
         .out_col     (st_col[i+1]),
         .out_start   (st_start[i+1])
      );
   end

   hbcn_neighbors #(.CW(CW)) u_neighbors (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (st_valid[CW]),
      .in_ready   (st_ready[CW]),
      .in_index   (st_index[CW]),
      .in_invalid (st_invalid[CW]),
      .in_col     (st_col[CW]),
      .in_start   (st_start[CW]),
      .rsp_if     (rsp_if)
   );

endmodule

/* dv/hbcn_neighbor_checker.sv */
// transaction checker for the hex board neighbour block: predicts each response
// from the accepted requests and the board radius register, compares in order
// depends on hbcn_pkg and the channel interfaces in hbcn_if
module hbcn_neighbor_checker #(
   parameter int MAX_RADIUS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   hbcn_req_if                         req_mon,
   hbcn_rsp_if                         rsp_mon,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hbcn_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hbcn_pkg::DATA_W-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import hbcn_pkg::*;

   localparam int OFF_BOARD  = -1;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic signed [COL_W-1:0] column;
      logic [ROW_W-1:0]        row;
      logic signed [NB_W-1:0]  up;
      logic signed [NB_W-1:0]  up_right;
      logic signed [NB_W-1:0]  down_right;
      logic signed [NB_W-1:0]  down;
      logic signed [NB_W-1:0]  down_left;
      logic signed [NB_W-1:0]  up_left;
      logic                    invalid;
   } cell_result_type;

   typedef struct {
      cell_result_type  res;
      logic [IDX_W-1:0] cell_index;
      logic [RAD_W-1:0] radius;
   } cell_lookup_type;

   logic [RAD_W-1:0] radius_reg = RADIUS_RESET;
   cell_lookup_type  expected_cells[$];

   assign pending = expected_cells.size();

   // column, row and six neighbour indices of one cell on a board of the given radius
   function automatic cell_result_type locate_neighbours(logic [RAD_W-1:0] radius_val,
                                                         logic [IDX_W-1:0] idx);
      cell_result_type res;
      int r, n, cells, col, start, len, row, ac, last;
      int up, upr, dnr, dn, dnl, upl;
      res = '0;
      r = int'(radius_val);
      if (r < 1) r = 1;
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      n = int'(idx);
      cells = 3 * r * (r - 1) + 1;
      if (n >= cells) begin
         res.invalid = 1'b1;
         return res;
      end
      // walk column starts until the index falls inside one
      start = 0;
      for (col = -(r - 1); col < r - 1; col++) begin
         len = 2 * r - 1 - (col < 0 ? -col : col);
         if (n < start + len) break;
         start += len;
      end
      row  = n - start;
      ac   = col < 0 ? -col : col;
      last = 2 * r - 2 - ac;

      up = (row == 0) ? OFF_BOARD : n - 1;
      dn = (row == last) ? OFF_BOARD : n + 1;

      if ((row == 0 && col >= 0) || col == r - 1) upr = OFF_BOARD;
      else upr = n + 2 * r - ac - 2 + (col < 0 ? 1 : 0);

      if ((row == last && col >= 0) || col == r - 1) dnr = OFF_BOARD;
      else dnr = n + 2 * r - ac - (col >= 0 ? 1 : 0);

      if ((row == last && col <= 0) || col == -(r - 1)) dnl = OFF_BOARD;
      else dnl = n - 2 * r + ac + 2 - (col > 0 ? 1 : 0);

      if ((row == 0 && col <= 0) || col == -(r - 1)) upl = OFF_BOARD;
      else upl = n - 2 * r + ac + (col <= 0 ? 1 : 0);

      res.column     = COL_W'(col);
      res.row        = ROW_W'(row);
      res.up         = NB_W'(up);
      res.up_right   = NB_W'(upr);
      res.down_right = NB_W'(dnr);
      res.down       = NB_W'(dn);
      res.down_left  = NB_W'(dnl);
      res.up_left    = NB_W'(upl);
      return res;
   endfunction

   // one field of a response against its prediction
   function automatic bit field_ok(string fname, cell_lookup_type want, int exp_val,
                                   int act_val, bit show);
      if (exp_val == act_val) return 1'b1;
      if (show)
         $display("%t mismatch cell %0d radius %0d %s: expected %0d, got %0d",
                  $time, want.cell_index, want.radius, fname, exp_val, act_val);
      return 1'b0;
   endfunction

   // track the radius register, queue predictions, compare responses
   always @(posedge clock) begin
      cell_lookup_type want;
      bit              ok;
      bit              show;
      if (reset) begin
         radius_reg <= RADIUS_RESET;
         expected_cells.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_BOARD_RADIUS)
            radius_reg <= csr_pwdata[RAD_W-1:0];

         if (req_mon.valid && req_mon.ready) begin
            want.res        = locate_neighbours(radius_reg, req_mon.cell_index);
            want.cell_index = req_mon.cell_index;
            want.radius     = radius_reg;
            expected_cells.push_back(want);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            show = fail_count < SHOW_LIMIT;
            if (expected_cells.size() == 0) begin
               if (show) $display("%t response transaction with nothing expected", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_cells.pop_front();
               ok = field_ok("column", want, want.res.column, rsp_mon.column, show)
                  & field_ok("row", want, want.res.row, rsp_mon.row, show)
                  & field_ok("nb_up", want, want.res.up, rsp_mon.nb_up, show)
                  & field_ok("nb_up_right", want, want.res.up_right,
                             rsp_mon.nb_up_right, show)
                  & field_ok("nb_down_right", want, want.res.down_right,
                             rsp_mon.nb_down_right, show)
                  & field_ok("nb_down", want, want.res.down, rsp_mon.nb_down, show)
                  & field_ok("nb_down_left", want, want.res.down_left,
                             rsp_mon.nb_down_left, show)
                  & field_ok("nb_up_left", want, want.res.up_left,
                             rsp_mon.nb_up_left, show)
                  & field_ok("invalid", want, want.res.invalid, rsp_mon.invalid, show);
               if (!ok) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

/* dv/tb_top.sv */
// top of the hex board neighbour testbench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict
// depends on hbcn_pkg, hbcn_if, the block's rtl and hbcn_neighbor_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hbcn_pkg::*;

   localparam int MAX_RADIUS      = 32;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 20;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending;
   int                idle_cycles;
   int                burst_left;
   int                radius_now;

   hbcn_req_if req_chan ();
   hbcn_rsp_if rsp_chan ();

   hex_board_cell_neighbors_top #(
      .MAX_RADIUS(MAX_RADIUS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_chan),
      .rsp_if     (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   hbcn_neighbor_checker #(
      .MAX_RADIUS(MAX_RADIUS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_pready (csr_pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cell count of the board that a radius register value selects
   function automatic int board_cells(int reg_value);
      int r;
      r = reg_value < 1 ? 1 : (reg_value > MAX_RADIUS ? MAX_RADIUS : reg_value);
      return 3 * r * (r - 1) + 1;
   endfunction

   // mostly cells on the board, some just past the edge, some anywhere
   function automatic int pick_index(int cells);
      int v;
      case ($urandom_range(0, 19))
         0: v = $urandom_range(0, (1 << IDX_W) - 1);
         1: begin
            v = cells + $urandom_range(0, 2);
            if (v > (1 << IDX_W) - 1) v = (1 << IDX_W) - 1;
         end
         2: v = cells - 1;
         default: v = $urandom_range(0, cells - 1);
      endcase
      return v;
   endfunction

   // one request transaction, with a random gap at the start of each burst
   task automatic send_cell(int idx);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 12)) @(negedge clock) req_chan.valid = 1'b0;
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid      = 1'b1;
      req_chan.cell_index = IDX_W'(idx);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // radius register write once the block has drained
   task automatic set_radius(int value);
      @(negedge clock) req_chan.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_BOARD_RADIUS, 2'b00};
      csr_pwdata  = ($urandom & ~32'h3F) | DATA_W'(value);
      @(negedge clock) csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      radius_now  = value;
   endtask

   // response back-pressure in one of four randomly picked patterns, one of them with no stalls
   initial begin
      int mode;
      int stall_left;
      int cyc;
      rsp_chan.ready = 1'b0;
      mode = 0;
      stall_left = 0;
      cyc = 0;
      forever begin
         @(negedge clock);
         if (cyc % 200 == 0) mode = $urandom_range(0, 3);
         cyc++;
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            case (mode)
               1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
               2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 6);
               3: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
               default: ;
            endcase
         end
      end
   end

   // request and register stimulus, then drain and verdict
   initial begin
      automatic int corner_r5[] = '{0, 4, 26, 30, 34, 35, 56, 60, 61, 4095};
      automatic int corner_r32[] = '{0, 62, 2976, 2977};
      automatic int corner_r2[] = '{0, 3, 6, 7};
      automatic int radius_plan[10] = '{32, 1, 0, 2, 63, 3, 17, 40, 31, 5};
      req_chan.valid      = 1'b0;
      req_chan.cell_index = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 0;
      radius_now  = RADIUS_RESET;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // corners, centre and column edges at the reset radius, then tiny and full boards
      foreach (corner_r5[i]) send_cell(corner_r5[i]);
      set_radius(1);
      send_cell(0);
      send_cell(1);
      set_radius(0);
      send_cell(0);
      send_cell(4095);
      set_radius(32);
      foreach (corner_r32[i]) send_cell(corner_r32[i]);
      set_radius(2);
      foreach (corner_r2[i]) send_cell(corner_r2[i]);

      // random phases over a spread of radii, extremes and out-of-range values included
      radius_plan[6] = $urandom_range(4, 31);
      radius_plan[7] = $urandom_range(33, 62);
      foreach (radius_plan[p]) begin
         set_radius(radius_plan[p]);
         repeat (ITEMS_PER_PHASE) send_cell(pick_index(board_cells(radius_now)));
      end

      @(negedge clock) req_chan.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
                   (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/hbcn_pkg.sv
hdl/hbcn_if.sv
hdl/hbcn_csr.sv
hdl/hbcn_search_stage.sv
hdl/hbcn_neighbors.sv
hdl/hex_board_cell_neighbors_top.sv
dv/hbcn_neighbor_checker.sv
dv/tb_top.sv
